### hdl/cmmn_pkg.sv
// Package for the column min-max normaliser: payload word types, codes,
// fixed widths and the request/response structs of the shared divider.
// Used by every module in the hdl folder but cmmn_store; depends on nothing else.
package cmmn_pkg;

  // Default tensor limits, handed to the top level as parameter defaults.
  localparam int DEF_MAX_COLUMNS = 16;
  localparam int DEF_MAX_ROWS    = 32;
  localparam int DEF_MAX_LAYERS  = 8;

  // Fixed field widths.
  localparam int SAMPLE_W   = 32;
  localparam int DIFF_W     = SAMPLE_W + 1;  // difference of two samples
  localparam int FRAC_W     = 16;            // fraction bits of the result
  localparam int NORM_W     = FRAC_W + 1;    // unsigned Q1.16
  localparam int COL_OUT_W  = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  // Quotient/dividend shift register of the divider. Wide enough for the
  // element counter at the largest supported tensor (64 x 1024 x 256).
  localparam int QUO_W  = 25;
  localparam int STEP_W = 5;

  localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << FRAC_W;

  // Operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Status codes.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LAYER_COUNT  = 2'd2;

  // Input word.
  typedef struct packed {
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [NORM_W-1:0]    norm_value;
    logic [COL_OUT_W-1:0] column_index;
    logic                 is_last;
    logic                 status;
  } result_t;

  // Request to the shared divider: one-cycle start plus operands.
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIFF_W-1:0] rem_init;
    logic [QUO_W-1:0]  quo_init;
    logic [DIFF_W-1:0] divisor;
  } div_req_t;

  // Response of the shared divider: done pulses once, results then hold.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIFF_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
  } div_rsp_t;

endpackage

### hdl/cmmn_store.sv
// Sample store of the column min-max normaliser: one write port and one
// read port with registered read data. Depends on nothing but its parameters.
module cmmn_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/cmmn_colstat.sv
// Per-column running minimum and maximum of the column min-max normaliser.
// Depends on cmmn_pkg for the sample width.
module cmmn_colstat import cmmn_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int COL_W       = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic                       first,
  input  logic [COL_W-1:0]           col,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [SAMPLE_W-1:0] lo,
  output logic signed [SAMPLE_W-1:0] hi
);

  logic signed [SAMPLE_W-1:0] col_min [MAX_COLUMNS];
  logic signed [SAMPLE_W-1:0] col_max [MAX_COLUMNS];

  // The first sample of a column sets both bounds; later ones widen them.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        col_min[i] <= '0;
        col_max[i] <= '0;
      end
    end else if (wr_en) begin
      if (first) begin
        col_min[col] <= sample;
        col_max[col] <= sample;
      end else begin
        if (sample > col_max[col]) begin
          col_max[col] <= sample;
        end
        if (sample < col_min[col]) begin
          col_min[col] <= sample;
        end
      end
    end
  end

  // Read at the same column.
  assign lo = col_min[col];
  assign hi = col_max[col];

endmodule

### hdl/cmmn_divider.sv
// Shared restoring divider of the column min-max normaliser: one quotient
// bit per cycle. Depends on cmmn_pkg for the request and response structs.
module cmmn_divider import cmmn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIFF_W-1:0] rem;
  logic [QUO_W-1:0]  quo;
  logic [DIFF_W-1:0] divisor;
  logic [STEP_W-1:0] count;
  logic              active;
  logic              done;

  logic [DIFF_W:0]   shifted;
  logic [DIFF_W:0]   diff;
  logic              ge;

  // One step: shift the next dividend bit into the remainder and subtract
  // the divisor when it fits.
  always_comb begin
    shifted = {rem, quo[QUO_W-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = (shifted >= {1'b0, divisor});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
      end else if (active && (count == STEP_W'(1))) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      quo     <= req.quo_init;
      divisor <= req.divisor;
      count   <= req.steps;
    end else if (active) begin
      rem   <= ge ? diff[DIFF_W-1:0] : shifted[DIFF_W-1:0];
      quo   <= {quo[QUO_W-2:0], ge};
      count <= count - STEP_W'(1);
    end
  end

  assign rsp.busy = active;
  assign rsp.done = done;
  assign rsp.rem  = rem;
  assign rsp.quo  = quo;

endmodule

### hdl/column_minmax_normaliser.sv
// Top level of the column min-max normaliser: sequencer, configuration
// registers and element counters. Depends on cmmn_pkg, cmmn_store,
// cmmn_colstat and cmmn_divider.
//
// Usage. A word on item is taken at a rising edge with start high and busy
// low; busy stays high until the word is finished and the next word can be
// taken once busy has dropped. A load word (opcode 0) stores one signed
// Q16.16 sample, column fastest, then row, then layer, and updates that
// column's minimum and maximum; it gives no result. A fetch word (opcode 1)
// gives one result word, shown with result_valid for a single cycle from the
// edge at which busy drops; the receiver cannot stall it. A fetch before the
// tensor is complete shows status not_ready. A fetch during the drain reads
// the store and forms the column difference: a value that clamps to 0 or one
// shows after the EXEC, READ and PREP states, any other runs 16 steps of the
// shared divider and shows when the divider is done. After column_count is
// written, the next word first runs two modulo passes on the same divider,
// once, to realign the column counters. Configuration words are always taken.
// Reset (rst, synchronous) empties the tensor, clears all bounds and sets
// every count register to 1; the store keeps its data.
module column_minmax_normaliser import cmmn_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_LAYERS  = DEF_MAX_LAYERS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  output logic                   result_valid,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS * MAX_LAYERS;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CC_W   = $clog2(MAX_COLUMNS + 1);
  localparam int RC_W   = $clog2(MAX_ROWS + 1);
  localparam int LC_W   = $clog2(MAX_LAYERS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SYNC_LOAD,
    S_SYNC_FETCH,
    S_EXEC,
    S_READ,
    S_PREP,
    S_DIV
  } state_t;

  state_t state;

  // Configuration registers.
  logic [4:0] column_count;
  logic [5:0] row_count;
  logic [3:0] layer_count;

  // Held input word.
  logic                       op;
  logic signed [SAMPLE_W-1:0] smp;

  // Tensor bookkeeping.
  logic [CNT_W-1:0] load_count;
  logic [CNT_W-1:0] fetch_count;
  logic [COL_W-1:0] load_col;
  logic [COL_W-1:0] fetch_col;
  logic             drain;
  logic             dirty;
  logic [CNT_W-1:0] total;

  // Fetch datapath registers.
  logic [COL_W-1:0]         col_r;
  logic                     last_r;
  logic signed [DIFF_W-1:0] d_r;
  logic signed [DIFF_W-1:0] range_r;

  // Combinational signals.
  logic [CC_W-1:0]  cols_eff;
  logic [RC_W-1:0]  rows_eff;
  logic [LC_W-1:0]  layers_eff;
  logic [CNT_W-1:0] total_next;
  logic             restart;
  logic [CNT_W-1:0] lc;
  logic [CNT_W-1:0] lc_next;
  logic [COL_W-1:0] lcol;
  logic [COL_W-1:0] lcol_next;
  logic             first;
  logic             fwrap;
  logic [CNT_W-1:0] fidx;
  logic [COL_W-1:0] fcol;
  logic [COL_W-1:0] fcol_next;
  logic             flast;
  logic             store_wr;
  logic             store_rd;
  logic [SAMPLE_W-1:0] rd_data;
  logic [COL_W-1:0] stat_col;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;
  logic signed [DIFF_W-1:0] d_next;
  logic signed [DIFF_W-1:0] range_next;
  logic             degenerate;
  logic             saturate;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp the count registers to their legal ranges.
  always_comb begin
    if (column_count == '0) begin
      cols_eff = CC_W'(1);
    end else if (32'(column_count) > MAX_COLUMNS) begin
      cols_eff = CC_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CC_W'(column_count);
    end
    if (row_count == '0) begin
      rows_eff = RC_W'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      rows_eff = RC_W'(MAX_ROWS);
    end else begin
      rows_eff = RC_W'(row_count);
    end
    if (layer_count == '0) begin
      layers_eff = LC_W'(1);
    end else if (32'(layer_count) > MAX_LAYERS) begin
      layers_eff = LC_W'(MAX_LAYERS);
    end else begin
      layers_eff = LC_W'(layer_count);
    end
    total_next = CNT_W'(cols_eff) * CNT_W'(rows_eff) * CNT_W'(layers_eff);
  end

  // Load position: a load in the drain, or past a shrunken tensor, restarts.
  always_comb begin
    restart   = drain || (load_count >= total);
    lc        = restart ? '0 : load_count;
    lcol      = restart ? '0 : load_col;
    lc_next   = lc + CNT_W'(1);
    lcol_next = ((CC_W'(lcol) + CC_W'(1)) == cols_eff) ? '0 : lcol + COL_W'(1);
    first     = (lc < CNT_W'(cols_eff));
  end

  // Fetch position: an index past a shrunken tensor wraps to the start.
  always_comb begin
    fwrap     = (fetch_count >= total);
    fidx      = fwrap ? '0 : fetch_count;
    fcol      = fwrap ? '0 : fetch_col;
    fcol_next = ((CC_W'(fcol) + CC_W'(1)) == cols_eff) ? '0 : fcol + COL_W'(1);
    flast     = ((fidx + CNT_W'(1)) == total);
  end

  // Store and bound table controls.
  always_comb begin
    store_wr = (state == S_EXEC) && (op == OP_LOAD);
    store_rd = (state == S_EXEC) && (op == OP_FETCH) && drain;
    stat_col = (state == S_EXEC) ? lcol : col_r;
  end

  // Offset from the column minimum and the column span.
  always_comb begin
    d_next     = {rd_data[SAMPLE_W-1], rd_data} - {lo[SAMPLE_W-1], lo};
    range_next = {hi[SAMPLE_W-1], hi} - {lo[SAMPLE_W-1], lo};
    degenerate = range_r[DIFF_W-1] || (range_r == '0) || d_r[DIFF_W-1] || (d_r == '0);
    saturate   = (d_r >= range_r);
  end

  // Divider requests: modulo passes for counter realignment, and the
  // fraction division of a fetch.
  always_comb begin
    div_req = '0;
    case (state)
      S_IDLE: begin
        if (start && dirty) begin
          div_req.start    = 1'b1;
          div_req.steps    = STEP_W'(CNT_W);
          div_req.quo_init = QUO_W'(load_count) << (QUO_W - CNT_W);
          div_req.divisor  = DIFF_W'(cols_eff);
        end
      end
      S_SYNC_LOAD: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.steps    = STEP_W'(CNT_W);
          div_req.quo_init = QUO_W'(fetch_count) << (QUO_W - CNT_W);
          div_req.divisor  = DIFF_W'(cols_eff);
        end
      end
      S_PREP: begin
        if (!degenerate && !saturate) begin
          div_req.start    = 1'b1;
          div_req.steps    = STEP_W'(FRAC_W);
          div_req.rem_init = d_r;
          div_req.divisor  = range_r;
        end
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Sequencer, configuration registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= 5'd1;
      row_count    <= 6'd1;
      layer_count  <= 4'd1;
      load_count   <= '0;
      fetch_count  <= '0;
      load_col     <= '0;
      fetch_col    <= '0;
      drain        <= 1'b0;
      dirty        <= 1'b0;
      total        <= CNT_W'(1);
      result_valid <= 1'b0;
      result       <= '0;
    end else begin
      total        <= total_next;
      result_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (start) begin
            op    <= item.opcode;
            smp   <= item.sample;
            state <= dirty ? S_SYNC_LOAD : S_EXEC;
          end
        end
        S_SYNC_LOAD: begin
          if (div_rsp.done) begin
            load_col <= div_rsp.rem[COL_W-1:0];
            state    <= S_SYNC_FETCH;
          end
        end
        S_SYNC_FETCH: begin
          if (div_rsp.done) begin
            fetch_col <= div_rsp.rem[COL_W-1:0];
            dirty     <= 1'b0;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (op == OP_LOAD) begin
            load_count <= lc_next;
            load_col   <= lcol_next;
            if (lc_next >= total) begin
              drain       <= 1'b1;
              fetch_count <= '0;
              fetch_col   <= '0;
            end else if (restart) begin
              drain       <= 1'b0;
              fetch_count <= '0;
              fetch_col   <= '0;
            end
            state <= S_IDLE;
          end else if (!drain) begin
            result_valid        <= 1'b1;
            result.norm_value   <= '0;
            result.column_index <= '0;
            result.is_last      <= 1'b0;
            result.status       <= STATUS_NOT_READY;
            state               <= S_IDLE;
          end else begin
            col_r       <= fcol;
            last_r      <= flast;
            fetch_count <= flast ? '0 : fidx + CNT_W'(1);
            fetch_col   <= flast ? '0 : fcol_next;
            state       <= S_READ;
          end
        end
        S_READ: begin
          d_r     <= d_next;
          range_r <= range_next;
          state   <= S_PREP;
        end
        S_PREP: begin
          if (degenerate || saturate) begin
            result_valid        <= 1'b1;
            result.norm_value   <= degenerate ? '0 : NORM_ONE;
            result.column_index <= COL_OUT_W'(col_r);
            result.is_last      <= last_r;
            result.status       <= STATUS_OK;
            state               <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            result_valid        <= 1'b1;
            result.norm_value   <= NORM_W'(div_rsp.quo[FRAC_W-1:0]);
            result.column_index <= COL_OUT_W'(col_r);
            result.is_last      <= last_r;
            result.status       <= STATUS_OK;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Configuration writes; a new column count forces a realignment.
      if (cfg_valid) begin
        case (cfg_index)
          REG_COLUMN_COUNT: begin
            column_count <= cfg_data[4:0];
            dirty        <= 1'b1;
          end
          REG_ROW_COUNT: begin
            row_count <= cfg_data[5:0];
          end
          REG_LAYER_COUNT: begin
            layer_count <= cfg_data[3:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  cmmn_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (lc[ADDR_W-1:0]),
    .wr_data (smp),
    .rd_en   (store_rd),
    .rd_addr (fidx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  cmmn_colstat #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .COL_W       (COL_W)
  ) u_colstat (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (store_wr),
    .first  (first),
    .col    (stat_col),
    .sample (smp),
    .lo     (lo),
    .hi     (hi)
  );

  cmmn_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // A result word is a single-cycle strobe.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

  // The divider only runs while a word is in progress.
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> busy)
    else $error("divider active while the block is idle");

  // A normalised value never exceeds one.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == STATUS_OK)) |-> (result.norm_value <= NORM_ONE))
    else $error("normalised value above one");

  // A not-ready answer carries an empty payload.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == STATUS_NOT_READY)) |->
      ((result.norm_value == '0) && (result.column_index == '0) && !result.is_last))
    else $error("not-ready result with a payload");

  // A word taken always makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

endmodule

### dv/column_minmax_normaliser_checker.sv
// Checker for the column min-max normaliser: watches the word, result and
// register channels, predicts every result word and compares it field by field.
// Depends on cmmn_pkg for the payload types, codes and widths.
module column_minmax_normaliser_checker import cmmn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  item_t                  item,
  input  logic                   result_valid,
  input  result_t                result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = DEF_MAX_COLUMNS * DEF_MAX_ROWS * DEF_MAX_LAYERS;

  // Shadow of the tensor store, the column bounds and the element counters.
  logic [SAMPLE_W-1:0]        samples [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0] col_lo [DEF_MAX_COLUMNS];
  logic signed [SAMPLE_W-1:0] col_hi [DEF_MAX_COLUMNS];
  logic [12:0]                loaded;
  logic [12:0]                fetched;
  logic                       draining;

  // Shadow of the shape registers, raw as written.
  logic [4:0] reg_cols;
  logic [5:0] reg_rows;
  logic [3:0] reg_layers;

  // Result words still owed by the block, oldest first.
  result_t owed_results [$];

  // A zero count acts as one, a count over the limit acts as the limit.
  function automatic int effective(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int element_total();
    return effective(int'(reg_cols), DEF_MAX_COLUMNS)
         * effective(int'(reg_rows), DEF_MAX_ROWS)
         * effective(int'(reg_layers), DEF_MAX_LAYERS);
  endfunction

  // Maps the column minimum to 0 and the maximum to 1.0, clamping outside values.
  function automatic logic [NORM_W-1:0] rescale(longint v, longint lo, longint hi);
    longint span;
    longint d;
    span = hi - lo;
    d = v - lo;
    if (span <= 0 || d <= 0) return '0;
    if (d >= span) return NORM_ONE;
    return NORM_W'((d <<< FRAC_W) / span);
  endfunction

  // Advances the shadow state by one accepted word.
  task automatic take_word(input item_t w);
    int      tot;
    int      ncols;
    int      idx;
    int      c;
    result_t r;
    tot = element_total();
    ncols = effective(int'(reg_cols), DEF_MAX_COLUMNS);
    r = '0;
    if (w.opcode == OP_LOAD) begin
      // A load after a complete tensor, or past a shrunk one, starts over.
      if (draining || loaded >= tot) begin
        loaded = '0;
        fetched = '0;
        draining = 1'b0;
      end
      c = loaded % ncols;
      samples[loaded % STORE_DEPTH] = w.sample;
      if (loaded < ncols) begin
        col_lo[c] = w.sample;
        col_hi[c] = w.sample;
      end else begin
        if (w.sample > col_hi[c]) col_hi[c] = w.sample;
        if (w.sample < col_lo[c]) col_lo[c] = w.sample;
      end
      loaded = loaded + 1'b1;
      if (loaded >= tot) begin
        draining = 1'b1;
        fetched = '0;
      end
    end else if (!draining) begin
      r.status = STATUS_NOT_READY;
      owed_results = {owed_results, r};
    end else begin
      if (fetched >= tot) fetched = '0;
      idx = int'(fetched);
      c = idx % ncols;
      r.norm_value = rescale(longint'($signed(samples[idx % STORE_DEPTH])),
                             longint'(col_lo[c]), longint'(col_hi[c]));
      r.column_index = COL_OUT_W'(c);
      r.is_last = (idx + 1 == tot);
      r.status = STATUS_OK;
      fetched = r.is_last ? 13'd0 : 13'(idx + 1);
      owed_results = {owed_results, r};
    end
  endtask

  task automatic check_field(input string name, input logic [NORM_W-1:0] want,
                             input logic [NORM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEF_MAX_COLUMNS; i++) begin
        col_lo[i] = '0;
        col_hi[i] = '0;
      end
      loaded = '0;
      fetched = '0;
      draining = 1'b0;
      reg_cols = 5'd1;
      reg_rows = 6'd1;
      reg_layers = 4'd1;
      owed_results.delete();
    end else begin
      // Compare the result word on the port with the oldest one owed.
      if (result_valid) begin
        if (owed_results.size() == 0) begin
          $error("result word with no fetch outstanding");
          fail_count++;
        end else begin
          result_t want;
          want = owed_results.pop_front();
          check_field("norm_value", want.norm_value, result.norm_value);
          check_field("column_index", NORM_W'(want.column_index),
                      NORM_W'(result.column_index));
          check_field("is_last", NORM_W'(want.is_last), NORM_W'(result.is_last));
          check_field("status", NORM_W'(want.status), NORM_W'(result.status));
        end
      end
      // Register writes only change the shape used by later words.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COLUMN_COUNT: reg_cols = cfg_data[4:0];
          REG_ROW_COUNT: reg_rows = cfg_data;
          REG_LAYER_COUNT: reg_layers = cfg_data[3:0];
          default: ;
        endcase
      end
      if (start && !busy) take_word(item);
    end
    pending = owed_results.size();
  end

endmodule

### dv/column_minmax_normaliser_test.sv
// Top of the column min-max normaliser testbench: clock, reset, stimulus and
// verdict. Depends on cmmn_pkg, the column_minmax_normaliser RTL and the
// column_minmax_normaliser_checker module.
module column_minmax_normaliser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cmmn_pkg::*;

  localparam int WORD_TARGET   = 750;
  localparam int SETTLE_CYCLES = 64;

  // How the samples of one tensor are spread.
  typedef enum int {SPREAD_FULL, SPREAD_SMALL, SPREAD_EDGES, SPREAD_FLAT, SPREAD_NARROW} spread_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  item_t                  item = '0;
  logic                   result_valid;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_COLUMN_COUNT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fail_count;
  int                     pending;

  // Shape as last written, load position and how much of the store holds data.
  int cols_reg = 1;
  int rows_reg = 1;
  int layers_reg = 1;
  int load_pos = 0;
  bit draining = 1'b0;
  int filled = 0;
  int words_sent = 0;
  bit no_gaps = 1'b0;

  column_minmax_normaliser u_dut (.*);
  column_minmax_normaliser_checker u_checker (.*);

  always #1 clk = ~clk;

  initial begin
    #2ms;
    $display("column_minmax_normaliser_test NOT OK");
    $finish;
  end

  function automatic int effective(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int tensor_size();
    return effective(cols_reg, DEF_MAX_COLUMNS) * effective(rows_reg, DEF_MAX_ROWS)
         * effective(layers_reg, DEF_MAX_LAYERS);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(spread_t spread,
                                                      logic [SAMPLE_W-1:0] base);
    case (spread)
      SPREAD_FULL: return $urandom;
      SPREAD_SMALL: return SAMPLE_W'($urandom_range(0, 511) - 256);
      SPREAD_EDGES: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return '0;
          default: return $urandom;
        endcase
      end
      SPREAD_FLAT: return base;
      default: return base + $urandom_range(0, 3);
    endcase
  endfunction

  // Presents one word after a random gap and waits until the block takes it.
  // Start stays high afterward so back-to-back words never toggle it.
  task automatic push_word(input logic op, input logic [SAMPLE_W-1:0] value);
    int    gap;
    logic  taken;
    logic  kind;
    item_t w;
    kind = op;
    // A fetch that could reach a never-written store entry is sent as a load.
    if (kind == OP_FETCH && draining && tensor_size() > filled) kind = OP_LOAD;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.opcode = kind;
    w.sample = value;
    start <= 1'b1;
    item <= w;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    words_sent++;
    if (kind == OP_LOAD) begin
      if (draining || load_pos >= tensor_size()) begin
        load_pos = 0;
        draining = 1'b0;
      end
      load_pos++;
      if (load_pos > filled) filled = load_pos;
      if (load_pos >= tensor_size()) draining = 1'b1;
    end
  endtask

  // Waits until no result is owed and the block is idle, then lets it finish.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Writes all three shape registers while the block is idle.
  task automatic set_shape(input int c, input int r, input int l);
    settle();
    put_reg(REG_COLUMN_COUNT, CFG_DATA_W'(c));
    put_reg(REG_ROW_COUNT, CFG_DATA_W'(r));
    put_reg(REG_LAYER_COUNT, CFG_DATA_W'(l));
    cfg_valid <= 1'b0;
    cols_reg = c % 32;
    rows_reg = r % 64;
    layers_reg = l % 16;
  endtask

  task automatic set_small_shape();
    set_shape($urandom_range(0, 4) + 32 * $urandom_range(0, 1),
              $urandom_range(0, 4),
              $urandom_range(0, 2) + 16 * $urandom_range(0, 3));
  endtask

  // Loads one tensor and drains it, with stray fetches, aborted loads,
  // extra fetches that wrap around and loads that cut a drain short.
  task automatic run_tensor();
    int                  tot;
    int                  extra;
    spread_t             spread;
    logic [SAMPLE_W-1:0] base;
    tot = tensor_size();
    spread = spread_t'($urandom_range(0, 4));
    base = $urandom;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < tot; i++) begin
      if ($urandom_range(0, 15) == 0) push_word(OP_FETCH, $urandom);
      if ($urandom_range(0, 31) == 0) return;
      push_word(OP_LOAD, pick_sample(spread, base));
    end
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, tot) : 0;
    for (int i = 0; i < tot + extra; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        push_word(OP_LOAD, pick_sample(spread, base));
        return;
      end
      push_word(OP_FETCH, $urandom);
    end
  endtask

  initial begin
    int pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Fetch before any load, then a single-element tensor drained twice.
    push_word(OP_FETCH, '0);
    push_word(OP_LOAD, 32'h8000_0000);
    push_word(OP_FETCH, '0);
    push_word(OP_FETCH, 32'hffff_ffff);

    // Two columns spanning the whole sample range.
    set_shape(2, 2, 1);
    push_word(OP_LOAD, 32'h8000_0000);
    push_word(OP_LOAD, 32'h7fff_ffff);
    push_word(OP_LOAD, 32'h7fff_ffff);
    push_word(OP_LOAD, 32'h8000_0000);
    repeat (3) push_word(OP_FETCH, '0);

    // A load in the middle of the drain starts a new tensor.
    push_word(OP_LOAD, '0);
    push_word(OP_FETCH, '0);
    push_word(OP_LOAD, 32'h0003_0000);
    push_word(OP_LOAD, 32'hffff_0000);
    push_word(OP_LOAD, 32'h0001_8000);
    repeat (2) push_word(OP_FETCH, '0);

    // One column over the same data: samples fall outside that column's range.
    set_shape(1, 3, 1);
    repeat (3) push_word(OP_FETCH, '0);
    // Shrinking below the fetch position wraps the drain to the first element.
    set_shape(1, 1, 1);
    push_word(OP_FETCH, '0);

    // Each shape register at its limits.
    set_shape(31, 1, 1); run_tensor();
    set_shape(16, 1, 1); run_tensor();
    set_shape(1, 63, 1); run_tensor();
    set_shape(1, 32, 1); run_tensor();
    set_shape(1, 1, 15); run_tensor();
    set_shape(1, 1, 8); run_tensor();
    set_shape(0, 0, 0); run_tensor();

    // Random tensors, mostly small, with reshapes that keep the old data.
    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        set_small_shape();
      end else if (pick < 14) begin
        set_shape($urandom_range(12, 31), 1, $urandom_range(0, 2));
      end else if (pick < 17) begin
        set_small_shape();
        repeat ($urandom_range(1, 6)) push_word(OP_FETCH, $urandom);
      end
      run_tensor();
    end

    settle();
    if (fail_count == 0) $display("column_minmax_normaliser_test OK");
    else $display("column_minmax_normaliser_test NOT OK");
    $finish;
  end

endmodule
